FILE: sv/btss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btss_pkg;

    // Field widths.
    localparam int ANGLE_W   = 8;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SERVO1_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO1_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO2_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO2_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO3_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO3_B = 3'd5;

    // Register reset values.
    localparam logic [ANGLE_W-1:0] RST_SERVO1_A = 8'd20;
    localparam logic [ANGLE_W-1:0] RST_SERVO1_B = 8'd141;
    localparam logic [ANGLE_W-1:0] RST_SERVO2_A = 8'd120;
    localparam logic [ANGLE_W-1:0] RST_SERVO2_B = 8'd97;
    localparam logic [ANGLE_W-1:0] RST_SERVO3_A = 8'd128;
    localparam logic [ANGLE_W-1:0] RST_SERVO3_B = 8'd146;

    // Command codes.
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_SETUP = 1'b1;

    // Brushless command codes.
    localparam logic [1:0] BLDC_STOP = 2'd0;
    localparam logic [1:0] BLDC_UP   = 2'd1;
    localparam logic [1:0] BLDC_DOWN = 2'd2;

    typedef struct packed {
        logic              command;
        logic              triangle_pressed;
        logic              cross_pressed;
        logic              left_pressed;
        logic              right_pressed;
        logic              up_pressed;
        logic              down_pressed;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo1_angle;
        logic               servo1_write;
        logic [ANGLE_W-1:0] servo2_angle;
        logic [ANGLE_W-1:0] servo3_angle;
        logic               servo23_write;
        logic               offset_direction;
        logic               offset_run;
        logic [1:0]         bldc_command;
        logic               servo1_busy;
    } t_out_word;

    // Servo 1 request and status between the top level and the ramp unit.
    typedef struct packed {
        logic              accept;
        logic              setup;
        logic              triangle;
        logic [TIME_W-1:0] now_ms;
    } t_s1_req;

    typedef struct packed {
        logic [ANGLE_W-1:0] position;
        logic               write;
        logic               busy;
    } t_s1_status;

endpackage

`default_nettype wire

FILE: sv/btss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface btss_in_if;
    import btss_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/btss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface btss_out_if;
    import btss_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/btss_servo1.sv
`timescale 1ns / 1ps
`default_nettype none

module btss_servo1 #(
    parameter int STEP_INTERVAL_MS = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  btss_pkg::t_s1_req          i_req,
    input  wire  [btss_pkg::ANGLE_W-1:0]     i_angle_a,
    input  wire  [btss_pkg::ANGLE_W-1:0]     i_angle_b,
    output btss_pkg::t_s1_status             o_status
);
    import btss_pkg::*;

    localparam logic [TIME_W-1:0] STEP_TICKS = TIME_W'(STEP_INTERVAL_MS);

    logic               r_prev_triangle, n_prev_triangle;
    logic               r_toggle,        n_toggle;
    logic [ANGLE_W-1:0] r_position,      n_position;
    logic [ANGLE_W-1:0] r_target,        n_target;
    logic               r_ramp,          n_ramp;
    logic [TIME_W-1:0]  r_last_step,     n_last_step;

    logic               edge_seen;
    logic               ramp_on;
    logic               step_due;
    logic [TIME_W-1:0]  elapsed;
    logic               write_now;

    // Setup loads angle A; otherwise toggle on a rising edge, then take at most one degree toward the target.
    always_comb begin
        n_prev_triangle = r_prev_triangle;
        n_toggle        = r_toggle;
        n_position      = r_position;
        n_target        = r_target;
        n_ramp          = r_ramp;
        n_last_step     = r_last_step;
        write_now       = 1'b0;
        edge_seen       = i_req.triangle & ~r_prev_triangle;
        elapsed         = i_req.now_ms - r_last_step;
        ramp_on         = r_ramp | edge_seen;
        step_due        = ramp_on && (elapsed >= STEP_TICKS);
        if (i_req.setup) begin
            n_toggle   = 1'b0;
            n_position = i_angle_a;
            n_target   = i_angle_a;
            write_now  = 1'b1;
        end else begin
            n_prev_triangle = i_req.triangle;
            if (edge_seen) begin
                n_toggle = ~r_toggle;
                n_target = r_toggle ? i_angle_a : i_angle_b;
            end
            n_ramp = ramp_on;
            if (step_due) begin
                n_last_step = i_req.now_ms;
                write_now   = 1'b1;
                if (r_position < n_target) begin
                    n_position = r_position + 1'b1;
                end else if (r_position > n_target) begin
                    n_position = r_position - 1'b1;
                end
                if (n_position == n_target) begin
                    n_ramp = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_triangle <= 1'b0;
            r_toggle        <= 1'b0;
            r_position      <= RST_SERVO1_A;
            r_target        <= RST_SERVO1_A;
            r_ramp          <= 1'b0;
            r_last_step     <= '0;
        end else if (i_req.accept) begin
            r_prev_triangle <= n_prev_triangle;
            r_toggle        <= n_toggle;
            r_position      <= n_position;
            r_target        <= n_target;
            r_ramp          <= n_ramp;
            r_last_step     <= n_last_step;
        end
    end

    // Status after this word, for the result register.
    assign o_status.position = n_position;
    assign o_status.write    = write_now;
    assign o_status.busy     = n_ramp;

endmodule

`default_nettype wire

FILE: sv/button_toggled_servo_slew_control_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word        Meaning
// i_in      sink       t_in_word   one poll or setup command
// o_out     source     t_out_word  servo, motor and status word per input
// i_cfg_*   write      8-bit data  six angle registers, index 0..5
//
// The state updates at acceptance and the result lands in the output register
// on the same edge. A new word is taken every cycle while the output register
// is empty or being drained. When the sink stalls, one result waits in the
// output register and input is held off.
// Reset is synchronous and loads the register and state reset values.

module button_toggled_servo_slew_control_unit #(
    parameter int STEP_INTERVAL_MS = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    btss_in_if.sink                          i_in,
    btss_out_if.source                       o_out,
    input  wire                              i_cfg_we,
    input  wire  [btss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [btss_pkg::ANGLE_W-1:0]     i_cfg_data
);
    import btss_pkg::*;

    logic [ANGLE_W-1:0] r_angle [NUM_REGS];
    logic               r_prev_cross,   n_prev_cross;
    logic               r_servo23_tog,  n_servo23_tog;
    logic               r_held_dir,     n_held_dir;
    logic               r_out_valid;
    t_out_word          r_out,          n_out;

    logic       accept;
    logic       s23_write;
    logic       run;
    logic [1:0] bldc;
    t_s1_req    s1_req;
    t_s1_status s1_status;

    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign accept     = i_in.valid & i_in.ready;

    // Angle registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle[REG_SERVO1_A] <= RST_SERVO1_A;
            r_angle[REG_SERVO1_B] <= RST_SERVO1_B;
            r_angle[REG_SERVO2_A] <= RST_SERVO2_A;
            r_angle[REG_SERVO2_B] <= RST_SERVO2_B;
            r_angle[REG_SERVO3_A] <= RST_SERVO3_A;
            r_angle[REG_SERVO3_B] <= RST_SERVO3_B;
        end else if (i_cfg_we && (i_cfg_idx <= REG_SERVO3_B)) begin
            r_angle[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Servo 1 toggle and slew.
    assign s1_req.accept   = accept;
    assign s1_req.setup    = (i_in.data.command == CMD_SETUP);
    assign s1_req.triangle = i_in.data.triangle_pressed;
    assign s1_req.now_ms   = i_in.data.now_ms;

    btss_servo1 #(
        .STEP_INTERVAL_MS (STEP_INTERVAL_MS)
    ) u_servo1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s1_req),
        .i_angle_a (r_angle[REG_SERVO1_A]),
        .i_angle_b (r_angle[REG_SERVO1_B]),
        .o_status  (s1_status)
    );

    // Servos 2 and 3, offset motor and brushless command.
    always_comb begin
        n_prev_cross  = r_prev_cross;
        n_servo23_tog = r_servo23_tog;
        n_held_dir    = r_held_dir;
        s23_write     = 1'b0;
        run           = 1'b0;
        bldc          = BLDC_STOP;
        if (i_in.data.command == CMD_SETUP) begin
            n_servo23_tog = 1'b0;
            s23_write     = 1'b1;
        end else begin
            n_prev_cross = i_in.data.cross_pressed;
            if (i_in.data.cross_pressed && !r_prev_cross) begin
                n_servo23_tog = ~r_servo23_tog;
                s23_write     = 1'b1;
            end
            priority if (i_in.data.left_pressed) begin
                n_held_dir = 1'b1;
                run        = 1'b1;
            end else if (i_in.data.right_pressed) begin
                n_held_dir = 1'b0;
                run        = 1'b1;
            end else begin
                n_held_dir = r_held_dir;
                run        = 1'b0;
            end
            priority if (i_in.data.up_pressed) begin
                bldc = BLDC_UP;
            end else if (i_in.data.down_pressed) begin
                bldc = BLDC_DOWN;
            end else begin
                bldc = BLDC_STOP;
            end
        end
    end

    // Result word.
    always_comb begin
        n_out.servo1_angle     = s1_status.position;
        n_out.servo1_write     = s1_status.write;
        n_out.servo2_angle     = n_servo23_tog ? r_angle[REG_SERVO2_B]
                                               : r_angle[REG_SERVO2_A];
        n_out.servo3_angle     = n_servo23_tog ? r_angle[REG_SERVO3_B]
                                               : r_angle[REG_SERVO3_A];
        n_out.servo23_write    = s23_write;
        n_out.offset_direction = n_held_dir;
        n_out.offset_run       = run;
        n_out.bldc_command     = bldc;
        n_out.servo1_busy      = s1_status.busy;
    end

    // State of servos 2 and 3 and the offset motor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cross  <= 1'b0;
            r_servo23_tog <= 1'b0;
            r_held_dir    <= 1'b0;
        end else if (accept) begin
            r_prev_cross  <= n_prev_cross;
            r_servo23_tog <= n_servo23_tog;
            r_held_dir    <= n_held_dir;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire
